// File: sv/led_strip_animation_engine_defines.svh
// ----------------------------------------------------------------------------
// led strip animation engine assertion macros
// concurrent checks that vanish in synthesis
// ----------------------------------------------------------------------------
`ifndef LED_STRIP_ANIMATION_ENGINE_DEFINES_SVH
`define LED_STRIP_ANIMATION_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LSAE_ASSERT_IMP(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lsae assertion failed");
// next-cycle implication
`define LSAE_ASSERT_NXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lsae assertion failed");
`else
`define LSAE_ASSERT_IMP(lbl, ck, rst_n, ante, cons)
`define LSAE_ASSERT_NXT(lbl, ck, rst_n, ante, cons)
`endif

`endif

// File: sv/lsae_pkg.sv
// ----------------------------------------------------------------------------
// lsae_pkg
// shared types and constants of the led strip animation engine
// ----------------------------------------------------------------------------
package lsae_pkg;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_FILL  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_RAINBOW = 2'd0,
		MODE_CYCLE   = 2'd1,
		MODE_AURORA  = 2'd2,
		MODE_FADE    = 2'd3
	} mode_t;

	localparam logic REG_MODE = 1'b0;
	localparam logic REG_FADE = 1'b1;

	localparam logic [1:0]  MODE_RESET = 2'd3;
	localparam logic [7:0]  FADE_RESET = 8'd10;

	localparam logic [10:0] WRAP_RAINBOW = 11'd256;
	localparam logic [10:0] WRAP_CYCLE   = 11'd1280;
	localparam logic [10:0] WRAP_AURORA  = 11'd140;
	localparam logic [10:0] AURORA_TURN  = 11'd70;
	localparam logic [7:0]  AURORA_UP    = 8'd80;
	localparam logic [7:0]  AURORA_DOWN  = 8'd220;

	// divider handshake
	typedef struct packed {
		logic       start;
		logic [7:0] dividend;
		logic [7:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic       done;
		logic [7:0] quotient;
	} div_rsp_t;

	// colour wheel red-green-blue-red
	function automatic logic [23:0] wheel(input logic [7:0] pos);
		logic [7:0] q;
		logic [7:0] q3;
		logic [23:0] res;
		q = 8'd255 - pos;
		if (q < 8'd85) begin
			q3  = 8'(10'(q) * 10'd3);
			res = {8'd255 - q3, 8'd0, q3};
		end else if (q < 8'd170) begin
			q3  = 8'(10'(q - 8'd85) * 10'd3);
			res = {8'd0, q3, 8'd255 - q3};
		end else begin
			q3  = 8'(10'(q - 8'd170) * 10'd3);
			res = {q3, 8'd255 - q3, 8'd0};
		end
		return res;
	endfunction

endpackage

// File: sv/lsae_if.sv
// ----------------------------------------------------------------------------
// lsae channel interfaces
// valid/ready channels for commands and emitted pixels
// ----------------------------------------------------------------------------
interface lsae_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [4:0]  pixel_index;
	logic [23:0] rgb_value;

	modport source (output valid, cmd, pixel_index, rgb_value, input ready);
	modport sink   (input valid, cmd, pixel_index, rgb_value, output ready);
endinterface

interface lsae_out_if;
	logic        valid;
	logic        ready;
	logic [4:0]  out_index;
	logic [23:0] out_color;
	logic        last_pixel;

	modport source (output valid, out_index, out_color, last_pixel, input ready);
	modport sink   (input valid, out_index, out_color, last_pixel, output ready);
endinterface

// File: sv/lsae_div.sv
// ----------------------------------------------------------------------------
// lsae_div
// 8 by 8 bit restoring divider, one quotient bit a cycle
// ----------------------------------------------------------------------------
module lsae_div (
	input  logic              clk,
	input  logic              arst_n,
	input  lsae_pkg::div_req_t req,
	output lsae_pkg::div_rsp_t rsp
);
	import lsae_pkg::*;

	localparam logic [2:0] DIV_LAST = 3'd7;

	logic       busy_q;
	logic       done_q;
	logic [2:0] cnt_q;
	logic [7:0] rem_q;
	logic [7:0] quo_q;
	logic [7:0] dsr_q;
	logic [8:0] shifted;
	logic [8:0] trial;
	logic       fits;

	assign shifted = {rem_q, quo_q[7]};
	assign trial   = shifted - {1'b0, dsr_q};
	assign fits    = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			dsr_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				quo_q  <= req.dividend;
				dsr_q  <= req.divisor;
			end else if (busy_q) begin
				rem_q <= fits ? trial[7:0] : shifted[7:0];
				quo_q <= {quo_q[6:0], fits};
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == DIV_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// File: sv/led_strip_animation_engine.sv
// ----------------------------------------------------------------------------
// led_strip_animation_engine
// frame generator for an addressable rgb strip: rainbow, rainbow cycle,
// aurora and fade-to-target patterns, one frame of pixels per tick beat
// ----------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  in_ch     in    valid/ready      cmd, pixel_index, rgb_value
//  out_ch    out   valid/ready      out_index, out_color, last_pixel
//  apb       in    psel/penable     paddr, pwdata, prdata (mode, fade steps)
//
//  write, fill and unused commands are handled in the idle state itself
//  a tick walks the strip pixel by pixel: read, calculate and output in wheel
//  modes; in fade each colour channel passes through the shared divider (a
//  start, 8 quotient bits, a handoff), skipped when no steps are left
//  in_ch.ready is low from a tick beat until the last pixel beat is taken
//  output stalls hold the pixel in its register; frames need no clearing pass
// ----------------------------------------------------------------------------
`include "led_strip_animation_engine_defines.svh"

module led_strip_animation_engine #(
	parameter int NUM_PIXELS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	lsae_in_if.sink     in_ch,
	lsae_out_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import lsae_pkg::*;

	localparam int IW = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
	localparam logic [IW-1:0] LAST_PIX = IW'(NUM_PIXELS - 1);
	// per-pixel spread of 256/NUM_PIXELS kept as integer and fraction
	localparam logic [7:0] SPREAD_INT  = 8'(256 / NUM_PIXELS);
	localparam logic [6:0] SPREAD_FRAC = 7'(256 % NUM_PIXELS);
	localparam logic [6:0] NPIX7       = 7'(NUM_PIXELS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_CALC,
		S_FSTART,
		S_FWAIT,
		S_OUT
	} state_t;

	// configuration registers
	logic [1:0] mode_q;
	logic [7:0] fade_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RESET;
			fade_q <= FADE_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_MODE: mode_q <= pwdata[1:0];
				REG_FADE: fade_q <= pwdata[7:0];
				default:  mode_q <= mode_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MODE: prdata = {30'd0, mode_q};
			REG_FADE: prdata = {24'd0, fade_q};
			default:  prdata = '0;
		endcase
	end

	// frame memories and their valid bits; an unwritten current pixel reads
	// zero, an unwritten target pixel reads the last fill colour
	logic [23:0] cur_mem [NUM_PIXELS];
	logic [23:0] tgt_mem [NUM_PIXELS];
	logic [NUM_PIXELS-1:0] cvalid_q;
	logic [NUM_PIXELS-1:0] tvalid_q;
	logic [23:0] fill_q;
	logic [23:0] cur_rd_q;
	logic [23:0] cur_rd;
	logic [23:0] tgt_rd;
	logic [23:0] tgt_raw_q;
	logic        tvalid_rd_q;
	logic        cvalid_rd_q;

	state_t        state_q;
	logic [IW-1:0] pix_q;
	logic [10:0]   sc_q;
	logic [1:0]    ch_q;
	logic [23:0]   col_q;
	logic [7:0]    spread_q;
	logic [6:0]    frac_q;

	logic in_beat;
	logic out_beat;
	logic tgt_we;
	logic cur_we;
	logic [IW-1:0] wr_idx;

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_beat     = in_ch.valid && in_ch.ready;
	assign out_beat    = out_ch.valid && out_ch.ready;
	assign wr_idx      = IW'(in_ch.pixel_index);
	assign tgt_we      = in_beat && (in_ch.cmd == CMD_WRITE) &&
	                     (7'(in_ch.pixel_index) < NPIX7);
	assign cur_we      = out_beat;

	always_ff @(posedge clk) begin
		if (tgt_we) begin
			tgt_mem[wr_idx] <= in_ch.rgb_value;
		end
		if (cur_we) begin
			cur_mem[pix_q] <= col_q;
		end
		if (state_q == S_RD) begin
			cur_rd_q  <= cur_mem[pix_q];
			tgt_raw_q <= tgt_mem[pix_q];
		end
	end

	// valid-bit gating applied on the registered read data
	always_comb begin
		tgt_rd = tvalid_rd_q ? tgt_raw_q : fill_q;
		cur_rd = cvalid_rd_q ? cur_rd_q : 24'd0;
	end

	// next iteration count on a tick, wrapped by mode
	logic [10:0] sc_inc;
	logic [10:0] sc_tick;
	always_comb begin
		sc_inc = sc_q + 11'd1;
		unique case (mode_t'(mode_q))
			MODE_RAINBOW: sc_tick = (sc_inc > WRAP_RAINBOW) ? 11'd0 : sc_inc;
			MODE_CYCLE:   sc_tick = (sc_inc > WRAP_CYCLE)   ? 11'd0 : sc_inc;
			MODE_AURORA:  sc_tick = (sc_inc > WRAP_AURORA)  ? 11'd0 : sc_inc;
			MODE_FADE:    sc_tick = (sc_inc >= 11'(fade_q)) ? 11'd0 : sc_inc;
			default:      sc_tick = sc_inc;
		endcase
	end

	// wheel position of the current pixel
	logic [7:0]  wpos;
	logic [23:0] wcol;
	always_comb begin
		unique case (mode_t'(mode_q))
			MODE_RAINBOW: wpos = 8'(pix_q) + sc_q[7:0];
			MODE_CYCLE:   wpos = spread_q + sc_q[7:0];
			MODE_AURORA:  wpos = (sc_q <= AURORA_TURN) ? AURORA_UP + sc_q[7:0]
			                                           : AURORA_DOWN - sc_q[7:0];
			default:      wpos = 8'(pix_q) + sc_q[7:0];
		endcase
		wcol = wheel(wpos);
	end

	// fade channel operands; the remaining step count is at most fade_q
	logic [7:0] div_n;
	logic [7:0] ch_c;
	logic [7:0] ch_t;
	logic       ch_neg;
	logic [7:0] ch_mag;
	logic [7:0] ch_new;
	div_req_t   dreq;
	div_rsp_t   drsp;

	assign div_n = fade_q - sc_q[7:0];

	always_comb begin
		unique case (ch_q)
			2'd0:    begin ch_c = cur_rd[23:16]; ch_t = tgt_rd[23:16]; end
			2'd1:    begin ch_c = cur_rd[15:8];  ch_t = tgt_rd[15:8];  end
			default: begin ch_c = cur_rd[7:0];   ch_t = tgt_rd[7:0];   end
		endcase
		ch_neg = ch_t < ch_c;
		ch_mag = ch_neg ? ch_c - ch_t : ch_t - ch_c;
		ch_new = ch_neg ? ch_c - drsp.quotient : ch_c + drsp.quotient;
	end

	assign dreq.start    = (state_q == S_FSTART) && (div_n != 8'd0);
	assign dreq.dividend = ch_mag;
	assign dreq.divisor  = div_n;

	lsae_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// spread accumulator step
	logic [7:0] frac_sum;
	assign frac_sum = {1'b0, frac_q} + {1'b0, SPREAD_FRAC};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pix_q       <= '0;
			sc_q        <= '0;
			ch_q        <= '0;
			col_q       <= '0;
			spread_q    <= '0;
			frac_q      <= '0;
			cvalid_q    <= '0;
			tvalid_q    <= '0;
			fill_q      <= '0;
			tvalid_rd_q <= 1'b0;
			cvalid_rd_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						unique case (cmd_t'(in_ch.cmd))
							CMD_TICK: begin
								sc_q     <= sc_tick;
								pix_q    <= '0;
								spread_q <= '0;
								frac_q   <= '0;
								state_q  <= S_RD;
							end
							CMD_WRITE: begin
								sc_q <= '0;
								if (tgt_we) begin
									tvalid_q[wr_idx] <= 1'b1;
								end
							end
							CMD_FILL: begin
								sc_q     <= '0;
								tvalid_q <= '0;
								fill_q   <= in_ch.rgb_value;
							end
							default: sc_q <= sc_q;
						endcase
					end
				end
				S_RD: begin
					tvalid_rd_q <= tvalid_q[pix_q];
					cvalid_rd_q <= cvalid_q[pix_q];
					state_q     <= S_CALC;
				end
				S_CALC: begin
					if (mode_t'(mode_q) == MODE_FADE) begin
						ch_q    <= 2'd0;
						state_q <= S_FSTART;
					end else begin
						col_q   <= wcol;
						state_q <= S_OUT;
					end
				end
				S_FSTART: begin
					if (div_n == 8'd0) begin
						// no steps left: jump straight to target
						col_q <= tgt_rd;
						state_q <= S_OUT;
					end else begin
						state_q <= S_FWAIT;
					end
				end
				S_FWAIT: begin
					if (drsp.done) begin
						unique case (ch_q)
							2'd0:    col_q[23:16] <= ch_new;
							2'd1:    col_q[15:8]  <= ch_new;
							default: col_q[7:0]   <= ch_new;
						endcase
						if (ch_q == 2'd2) begin
							state_q <= S_OUT;
						end else begin
							ch_q    <= ch_q + 2'd1;
							state_q <= S_FSTART;
						end
					end
				end
				S_OUT: begin
					if (out_beat) begin
						cvalid_q[pix_q] <= 1'b1;
						if (frac_sum >= {1'b0, NPIX7}) begin
							frac_q   <= 7'(frac_sum - {1'b0, NPIX7});
							spread_q <= spread_q + SPREAD_INT + 8'd1;
						end else begin
							frac_q   <= frac_sum[6:0];
							spread_q <= spread_q + SPREAD_INT;
						end
						if (pix_q == LAST_PIX) begin
							state_q <= S_IDLE;
						end else begin
							pix_q   <= pix_q + IW'(1);
							state_q <= S_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid      = (state_q == S_OUT);
	assign out_ch.out_index  = 5'(pix_q);
	assign out_ch.out_color  = col_q;
	assign out_ch.last_pixel = (pix_q == LAST_PIX);

	// assertions
	`LSAE_ASSERT_IMP(a_out_blocks_in, clk, arst_n, out_ch.valid, !in_ch.ready)
	`LSAE_ASSERT_NXT(a_tick_busy, clk, arst_n,
		in_beat && (in_ch.cmd == CMD_TICK), !in_ch.ready)
	`LSAE_ASSERT_IMP(a_div_idle_start, clk, arst_n, dreq.start, state_q == S_FSTART)
	`LSAE_ASSERT_NXT(a_last_ends, clk, arst_n,
		out_beat && out_ch.last_pixel, in_ch.ready)

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the led strip animation engine: commands are fed
// in random bursts, each tick beat is predicted as a full frame of pixel beats
// and every pixel beat is compared with the oldest expected one
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import lsae_pkg::*;

	localparam int NPIX        = 32;
	localparam int CYCLE_LIMIT = 5000000;

	typedef struct {
		cmd_t        cmd;
		logic [4:0]  index;
		logic [23:0] rgb;
	} command_t;

	typedef struct {
		logic [4:0]  index;
		logic [23:0] color;
		logic        last;
	} pixel_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	lsae_in_if  in_ch ();
	lsae_out_if out_ch ();

	led_strip_animation_engine #(.NUM_PIXELS(NPIX)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// pending commands and frame pixels still owed by the block
	command_t    cmd_q[$];
	pixel_t      pixel_q[$];
	int          errors;
	int          cycles;
	bit          hold_off;

	// shadow of the block state
	logic [23:0] shown[NPIX];
	logic [23:0] goal[NPIX];
	logic [10:0] iter;
	mode_t       mode;
	logic [7:0]  fade_len;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// colour wheel, red to green to blue and back
	function automatic logic [23:0] hue(input int p);
		int q;
		q = 255 - (p & 255);
		if (q < 85)
			return {8'(255 - 3 * q), 8'd0, 8'(3 * q)};
		if (q < 170) begin
			q -= 85;
			return {8'd0, 8'(3 * q), 8'(255 - 3 * q)};
		end
		q -= 170;
		return {8'(3 * q), 8'(255 - 3 * q), 8'd0};
	endfunction

	// one channel moves toward its goal, truncated toward zero
	function automatic logic [7:0] step_chan(input logic [7:0] c, input logic [7:0] t,
			input int d);
		int ci;
		int ti;
		ci = c;
		ti = t;
		if (d <= 0)
			return t;
		return 8'(ci + (ti - ci) / d);
	endfunction

	// advance the shadow frame for one accepted command beat
	function automatic void frame_update(input command_t c);
		int          d;
		logic [23:0] a;
		logic [23:0] g;
		pixel_t      px;
		case (c.cmd)
			CMD_WRITE: begin
				goal[c.index] = c.rgb;
				iter = '0;
			end
			CMD_FILL: begin
				foreach (goal[i]) goal[i] = c.rgb;
				iter = '0;
			end
			CMD_TICK: begin
				iter = iter + 11'd1;
				case (mode)
					MODE_RAINBOW: begin
						if (iter > WRAP_RAINBOW) iter = '0;
						foreach (shown[i]) shown[i] = hue(i + int'(iter));
					end
					MODE_CYCLE: begin
						if (iter > WRAP_CYCLE) iter = '0;
						foreach (shown[i]) shown[i] = hue(i * 256 / NPIX + int'(iter));
					end
					MODE_AURORA: begin
						if (iter > WRAP_AURORA) iter = '0;
						foreach (shown[i])
							shown[i] = (iter <= AURORA_TURN) ? hue(80 + int'(iter))
								: hue(220 - int'(iter));
					end
					default: begin
						if (iter >= 11'(fade_len)) iter = '0;
						d = int'(fade_len) - int'(iter);
						foreach (shown[i]) begin
							a = shown[i];
							g = goal[i];
							shown[i] = {step_chan(a[23:16], g[23:16], d),
								step_chan(a[15:8], g[15:8], d), step_chan(a[7:0], g[7:0], d)};
						end
					end
				endcase
				for (int i = 0; i < NPIX; i++) begin
					px.index = 5'(i);
					px.color = shown[i];
					px.last  = (i == NPIX - 1);
					pixel_q.push_back(px);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void push_cmd(input cmd_t k, input logic [4:0] ix, input logic [23:0] v);
		command_t c;
		c.cmd   = k;
		c.index = ix;
		c.rgb   = v;
		cmd_q.push_back(c);
	endfunction

	// random mix: tick_pct percent ticks, the rest writes, fills and unused codes
	task automatic add_random(input int n, input int tick_pct);
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < tick_pct)
				push_cmd(CMD_TICK, 5'($urandom), 24'($urandom));
			else if (r < tick_pct + (100 - tick_pct) * 6 / 10)
				push_cmd(CMD_WRITE, 5'($urandom), 24'($urandom));
			else if (r < tick_pct + (100 - tick_pct) * 8 / 10)
				push_cmd(CMD_FILL, 5'($urandom), 24'($urandom));
			else
				push_cmd(CMD_NONE, 5'($urandom), 24'($urandom));
		end
	endtask

	// wait until every command is taken and every pixel beat seen
	task automatic drain();
		while (cmd_q.size() != 0 || in_ch.valid || pixel_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// apb write: setup then access, register taken at the access edge
	task automatic reg_write(input logic sel, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (sel == REG_MODE)
			mode = mode_t'(val[1:0]);
		else
			fade_len = val[7:0];
	endtask

	// stimulus and configuration phases
	initial begin
		errors = 0;
		hold_off = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		foreach (shown[i]) begin
			shown[i] = '0;
			goal[i] = '0;
		end
		iter = '0;
		mode = mode_t'(MODE_RESET);
		fade_len = FADE_RESET;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, every command, unused code, reset settings
		push_cmd(CMD_TICK, 5'd0, 24'd0);
		push_cmd(CMD_FILL, 5'd0, 24'hFFFFFF);
		push_cmd(CMD_WRITE, 5'd0, 24'h000000);
		push_cmd(CMD_WRITE, 5'd31, 24'hFFFFFF);
		push_cmd(CMD_WRITE, 5'd15, 24'h123456);
		push_cmd(CMD_NONE, 5'd31, 24'hFFFFFF);
		push_cmd(CMD_TICK, 5'd31, 24'hFFFFFF);
		push_cmd(CMD_TICK, 5'd0, 24'd0);
		push_cmd(CMD_NONE, 5'd0, 24'd0);
		push_cmd(CMD_TICK, 5'd0, 24'd0);
		push_cmd(CMD_WRITE, 5'd7, 24'h00FF00);
		for (int k = 0; k < 11; k++) push_cmd(CMD_TICK, 5'd0, 24'd0);
		drain();

		// single step fade: jumps straight to the goal
		reg_write(REG_FADE, 32'd1);
		add_random(10, 50);
		drain();

		// zero fade steps behaves like a single step
		reg_write(REG_FADE, 32'd0);
		push_cmd(CMD_FILL, 5'd3, 24'hA5C3F0);
		add_random(6, 70);
		drain();

		// longest fade, with one full pause of the sender part way
		reg_write(REG_FADE, 32'd255);
		add_random(16, 60);
		while (cmd_q.size() > 8) @(posedge clk);
		hold_off = 1'b1;
		while (in_ch.valid || pixel_q.size() != 0) @(posedge clk);
		hold_off = 1'b0;
		drain();

		// rainbow long enough to pass its wrap, count cleared by a fill first
		reg_write(REG_MODE, 32'(MODE_RAINBOW));
		push_cmd(CMD_FILL, 5'd0, 24'h0000FF);
		for (int k = 0; k < 259; k++) begin
			if ($urandom_range(49) == 0) push_cmd(CMD_NONE, 5'($urandom), 24'($urandom));
			push_cmd(CMD_TICK, 5'($urandom), 24'($urandom));
		end
		drain();

		reg_write(REG_MODE, 32'(MODE_CYCLE));
		add_random(6, 80);
		drain();

		// aurora through its turn and its wrap
		reg_write(REG_MODE, 32'(MODE_AURORA));
		push_cmd(CMD_FILL, 5'd0, 24'h00FF00);
		for (int k = 0; k < 142; k++) push_cmd(CMD_TICK, 5'($urandom), 24'($urandom));
		drain();

		reg_write(REG_MODE, 32'(MODE_FADE));
		reg_write(REG_FADE, 32'd7);
		add_random(10, 50);
		drain();

		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// command driver: bursts of beats with random gaps
	int burst_left;
	int gap_left;
	initial begin
		in_ch.valid = 1'b0;
		in_ch.cmd = '0;
		in_ch.pixel_index = '0;
		in_ch.rgb_value = '0;
		burst_left = 0;
		gap_left = 0;
	end

	always @(posedge clk) begin
		command_t c;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				frame_update(command_t'{cmd_t'(in_ch.cmd), in_ch.pixel_index, in_ch.rgb_value});
			if (!in_ch.valid || in_ch.ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_ch.valid <= 1'b0;
				end else if (cmd_q.size() != 0 && !hold_off) begin
					c = cmd_q.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.cmd <= c.cmd;
					in_ch.pixel_index <= c.index;
					in_ch.rgb_value <= c.rgb;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(12, 1);
						gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// pixel receiver: alternates clean stretches with random stalls
	int stall_phase;
	initial begin
		out_ch.ready = 1'b0;
		stall_phase = 0;
	end

	always @(posedge clk) begin
		stall_phase <= stall_phase + 1;
		if (stall_phase[7])
			out_ch.ready <= 1'b1;
		else if (stall_phase[6])
			out_ch.ready <= ($urandom_range(3) != 0);
		else
			out_ch.ready <= ($urandom_range(7) < 2);
	end

	// pixel checker
	always @(posedge clk) begin
		pixel_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pixel_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected pixel beat index %0d colour %06h last %0b",
					$time, out_ch.out_index, out_ch.out_color, out_ch.last_pixel);
			end else begin
				e = pixel_q.pop_front();
				if (out_ch.out_index !== e.index) begin
					errors++;
					$display("%0t: out_index expected %0d actual %0d",
						$time, e.index, out_ch.out_index);
				end
				if (out_ch.out_color !== e.color) begin
					errors++;
					$display("%0t: out_color pixel %0d expected %06h actual %06h",
						$time, e.index, e.color, out_ch.out_color);
				end
				if (out_ch.last_pixel !== e.last) begin
					errors++;
					$display("%0t: last_pixel pixel %0d expected %0b actual %0b",
						$time, e.index, e.last, out_ch.last_pixel);
				end
			end
		end
	end

	// watchdog
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

endmodule

// File: led_strip_animation_engine.f
+incdir+sv
sv/lsae_pkg.sv
sv/lsae_if.sv
sv/lsae_div.sv
sv/led_strip_animation_engine.sv
tb/sv/tb_top.sv
